/* rtl/isar_pkg.sv */
`timescale 1ns / 1ps

package isar_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int POSITION_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic       CMD_ADD    = 1'b0;
  localparam logic       CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } in_t;

  typedef struct packed {
    logic [6:0] interval_total;
    logic [1:0] status;
  } out_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_WRITE2,
    ST_TAIL,
    ST_RESP
  } state_t;

endpackage

/* rtl/interval_set_add_remove_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   push / full            isar_pkg::in_t  (command, range_low, range_high)
// response  pop / empty            isar_pkg::out_t (interval_total, status)
//
// An item walks the stored intervals, a read step and an evaluate step per entry, plus
// a second write step for a split or insert; the single table read port sets this.
// Items with low above high go straight to the response without touching the table.
// Reset (rst, synchronous) empties the set and both transaction queues.
// Two-entry queues before and after the update engine let either side stall alone.

module interval_set_add_remove_top #(
  parameter int MAX_INTERVALS = isar_pkg::MAX_INTERVALS,
  parameter int POSITION_BITS = isar_pkg::POSITION_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  isar_pkg::in_t  request,
  input  logic           pop,
  output logic           empty,
  output isar_pkg::out_t response
);

  logic                       q_pop;
  logic                       q_empty;
  logic [2*POSITION_BITS+1:0] q_data;
  logic                       res_push;
  logic                       res_full;
  isar_pkg::out_t             res_data;
  logic [$bits(isar_pkg::out_t)-1:0] res_q;

  isar_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .q_empty (q_empty)
  );

  isar_engine #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .POSITION_BITS (POSITION_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  isar_fifo #(
    .WIDTH ($bits(isar_pkg::out_t)),
    .DEPTH (isar_pkg::QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign response = isar_pkg::out_t'(res_q);

endmodule

/* rtl/isar_fifo.sv */
`timescale 1ns / 1ps

module isar_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = isar_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wptr;
  logic [PTR_BITS-1:0] rptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == CNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_BITS'(DEPTH - 1)) ? '0 : wptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_BITS'(DEPTH - 1)) ? '0 : rptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= CNT_BITS'(DEPTH))
    else $error("queue fill above depth");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + CNT_BITS'(1)))
    else $error("queue fill did not grow on push");
  assert property (@(posedge clk) disable iff (rst) empty |-> (wptr == rptr))
    else $error("empty queue with unequal pointers");

endmodule

/* rtl/isar_front.sv */
`timescale 1ns / 1ps

module isar_front #(
  parameter int POSITION_BITS = isar_pkg::POSITION_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  isar_pkg::in_t                request,
  output logic                         full,
  input  logic                         q_pop,
  output logic [2*POSITION_BITS+1:0]   q_data,
  output logic                         q_empty
);

  localparam int PW = POSITION_BITS;

  logic [PW+31:0]        lo_ext;
  logic [PW+31:0]        hi_ext;
  logic [PW-1:0]         lo;
  logic [PW-1:0]         hi;
  isar_pkg::op_t         op;
  logic [2*PW+1:0]       item;

  assign lo_ext = {{PW{1'b0}}, request.range_low};
  assign hi_ext = {{PW{1'b0}}, request.range_high};
  assign lo     = lo_ext[PW-1:0];
  assign hi     = hi_ext[PW-1:0];

  always_comb begin
    if (lo > hi) begin
      op = isar_pkg::OP_BAD;
    end else if (request.command == isar_pkg::CMD_REMOVE) begin
      op = isar_pkg::OP_REMOVE;
    end else begin
      op = isar_pkg::OP_ADD;
    end
  end

  assign item = {op, lo, hi};

  isar_fifo #(
    .WIDTH (2 * PW + 2),
    .DEPTH (isar_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (item),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

endmodule

/* rtl/isar_engine.sv */
`timescale 1ns / 1ps

module isar_engine #(
  parameter int MAX_INTERVALS = isar_pkg::MAX_INTERVALS,
  parameter int POSITION_BITS = isar_pkg::POSITION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  logic [2*POSITION_BITS+1:0] q_data,
  output logic                       q_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output isar_pkg::out_t             res_data
);

  localparam int PW = POSITION_BITS;
  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int NW = $clog2(MAX_INTERVALS + 2);

  isar_pkg::state_t state;
  isar_pkg::state_t state_next;

  logic [2*PW-1:0] mem [2*MAX_INTERVALS];
  logic [2*PW-1:0] rdata;
  logic            rd_en;
  logic [IW:0]     rd_addr;
  logic            wr_en;
  logic [IW:0]     wr_addr;
  logic [2*PW-1:0] wr_data;

  logic            bank;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [NW-1:0]   n;
  logic            placed;
  logic [PW-1:0]   mlo;
  logic [PW-1:0]   mhi;
  isar_pkg::op_t   op;
  logic [PW-1:0]   lo;
  logic [PW-1:0]   hi;
  logic [2*PW-1:0] stash;
  logic [CW-1:0]   res_total;
  logic [1:0]      res_status;

  isar_pkg::op_t   q_op;
  logic [PW-1:0]   s;
  logic [PW-1:0]   e;
  logic [PW:0]     e_inc;
  logic [PW:0]     hi_inc;
  logic            w0_valid;
  logic [2*PW-1:0] w0;
  logic            w1_valid;
  logic [2*PW-1:0] w1;
  logic            merge;
  logic            set_placed;
  logic            last;
  logic            tail_write;
  logic [NW-1:0]   n_final;
  logic            table_full;
  logic [CW+6:0]   total_ext;

  assign q_op   = isar_pkg::op_t'(q_data[2*PW+1:2*PW]);
  assign s      = rdata[2*PW-1:PW];
  assign e      = rdata[PW-1:0];
  assign e_inc  = {1'b0, e} + (PW+1)'(1);
  assign hi_inc = {1'b0, hi} + (PW+1)'(1);
  assign last   = (idx + CW'(1) == count);

  always_comb begin
    w0_valid   = 1'b0;
    w0         = rdata;
    w1_valid   = 1'b0;
    w1         = rdata;
    merge      = 1'b0;
    set_placed = 1'b0;
    if (op == isar_pkg::OP_ADD) begin
      if (e_inc < {1'b0, lo}) begin
        w0_valid = 1'b1;
      end else if ({1'b0, s} > hi_inc) begin
        w0_valid = 1'b1;
        if (!placed) begin
          w0         = {mlo, mhi};
          w1_valid   = 1'b1;
          set_placed = 1'b1;
        end
      end else begin
        merge = 1'b1;
      end
    end else begin
      if (e < lo || s > hi) begin
        w0_valid = 1'b1;
      end else if (s < lo) begin
        w0_valid = 1'b1;
        w0       = {s, lo - PW'(1)};
        if (e > hi) begin
          w1_valid = 1'b1;
          w1       = {hi_inc[PW-1:0], e};
        end
      end else if (e > hi) begin
        w0_valid = 1'b1;
        w0       = {hi_inc[PW-1:0], e};
      end
    end
  end

  assign tail_write = (op == isar_pkg::OP_ADD) && !placed;
  assign n_final    = n + NW'(tail_write);
  assign table_full = (n_final > NW'(MAX_INTERVALS));

  always_comb begin
    state_next = state;
    unique case (state)
      isar_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (q_op == isar_pkg::OP_BAD) begin
            state_next = isar_pkg::ST_RESP;
          end else if (count == '0) begin
            state_next = isar_pkg::ST_TAIL;
          end else begin
            state_next = isar_pkg::ST_ISSUE;
          end
        end
      end
      isar_pkg::ST_ISSUE: state_next = isar_pkg::ST_EVAL;
      isar_pkg::ST_EVAL: begin
        if (w1_valid) begin
          state_next = isar_pkg::ST_WRITE2;
        end else if (last) begin
          state_next = isar_pkg::ST_TAIL;
        end else begin
          state_next = isar_pkg::ST_ISSUE;
        end
      end
      isar_pkg::ST_WRITE2: state_next = last ? isar_pkg::ST_TAIL : isar_pkg::ST_ISSUE;
      isar_pkg::ST_TAIL:   state_next = isar_pkg::ST_RESP;
      isar_pkg::ST_RESP: begin
        if (!res_full) begin
          state_next = isar_pkg::ST_IDLE;
        end
      end
      default: state_next = isar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    res_push = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = {bank, idx[IW-1:0]};
    wr_en    = 1'b0;
    wr_addr  = {~bank, n[IW-1:0]};
    wr_data  = w0;
    unique case (state)
      isar_pkg::ST_IDLE:   q_pop = !q_empty;
      isar_pkg::ST_ISSUE:  rd_en = 1'b1;
      isar_pkg::ST_EVAL:   wr_en = w0_valid;
      isar_pkg::ST_WRITE2: begin
        wr_en   = 1'b1;
        wr_data = stash;
      end
      isar_pkg::ST_TAIL: begin
        wr_en   = tail_write;
        wr_data = {mlo, mhi};
      end
      isar_pkg::ST_RESP:   res_push = !res_full;
      default: begin
      end
    endcase
    wr_en = wr_en && (n < NW'(MAX_INTERVALS));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isar_pkg::ST_IDLE;
      bank  <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == isar_pkg::ST_TAIL && !table_full) begin
        bank  <= ~bank;
        count <= n_final[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      isar_pkg::ST_IDLE: begin
        op         <= q_op;
        lo         <= q_data[2*PW-1:PW];
        hi         <= q_data[PW-1:0];
        mlo        <= q_data[2*PW-1:PW];
        mhi        <= q_data[PW-1:0];
        idx        <= '0;
        n          <= '0;
        placed     <= 1'b0;
        res_total  <= count;
        res_status <= isar_pkg::STATUS_BAD;
      end
      isar_pkg::ST_EVAL: begin
        if (w0_valid) begin
          n <= n + NW'(1);
        end
        if (set_placed) begin
          placed <= 1'b1;
        end
        if (merge) begin
          if (s < mlo) begin
            mlo <= s;
          end
          if (e > mhi) begin
            mhi <= e;
          end
        end
        stash <= w1;
        if (!w1_valid) begin
          idx <= idx + CW'(1);
        end
      end
      isar_pkg::ST_WRITE2: begin
        n   <= n + NW'(1);
        idx <= idx + CW'(1);
      end
      isar_pkg::ST_TAIL: begin
        if (table_full) begin
          res_total  <= count;
          res_status <= isar_pkg::STATUS_FULL;
        end else begin
          res_total  <= n_final[CW-1:0];
          res_status <= isar_pkg::STATUS_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign total_ext = {7'b0, res_total};
  assign res_data  = '{interval_total: total_ext[6:0], status: res_status};

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_INTERVALS))
    else $error("interval count above table size");
  assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> ($past(state) == isar_pkg::ST_TAIL))
    else $error("table bank swapped outside the final step");
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == isar_pkg::ST_EVAL || state == isar_pkg::ST_WRITE2 ||
               state == isar_pkg::ST_TAIL))
    else $error("table write outside the walk");
  assert property (@(posedge clk) disable iff (rst)
    (state == isar_pkg::ST_EVAL) |-> ($past(state) == isar_pkg::ST_ISSUE))
    else $error("entry evaluated without a read");

endmodule
